// ----- src/kmq_pkg.sv -----
package kmq_pkg;

	// Operation carried by one input item.
	typedef enum logic [1:0] {
		ACT_ENQUEUE  = 2'd0,
		ACT_READ     = 2'd1,
		ACT_CLEAR    = 2'd2,
		ACT_JOYSTICK = 2'd3
	} action_t;

	// Shift-force codes; the unused code acts as neutral.
	localparam logic [1:0] FORCE_NEUTRAL = 2'd0;
	localparam logic [1:0] FORCE_DOWN    = 2'd1;
	localparam logic [1:0] FORCE_UP      = 2'd2;

	// Shifted-mapping modes.
	localparam logic [1:0] SMODE_PLAIN  = 2'd0;
	localparam logic [1:0] SMODE_MAPPED = 2'd1;
	localparam logic [1:0] SMODE_IGNORE = 2'd2;

	// Configuration register indexes and widths.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 20;
	localparam logic [CFG_INDEX_W-1:0] CFG_THROTTLE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_SHIFT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_SHIFT = 2'd2;

	localparam int THROTTLE_W = 20;
	localparam int TIME_W     = 40;
	localparam int CODE_W     = 8;
	localparam int POS_W      = 6;

	localparam logic [THROTTLE_W-1:0] THROTTLE_RESET    = 20'd50000;
	localparam logic [CODE_W-1:0]     LEFT_SHIFT_RESET  = 8'hFE;
	localparam logic [CODE_W-1:0]     RIGHT_SHIFT_RESET = 8'hFF;

	// Byte 6 carries the joystick, byte 7 holds the shift keys.
	localparam int JOYSTICK_BYTE = 6;
	localparam int SHIFT_BYTE    = 7;
	localparam logic [7:0] FORCE_UP_MASK  = 8'h03;
	localparam logic [7:0] FORCE_DOWN_SET = 8'h01;

	// One queued key event.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              press;
		logic [POS_W-1:0]  plain_pos;
		logic [1:0]        plain_fc;
		logic [1:0]        smode;
		logic [POS_W-1:0]  shifted_pos;
		logic [1:0]        shifted_fc;
	} kev_t;

	localparam int KEV_W = $bits(kev_t);

	// Registered input item.
	typedef struct packed {
		action_t           action;
		logic [TIME_W-1:0] cycle_time;
		logic [7:0]        read_select;
		logic [7:0]        joystick_bits;
		kev_t              ev;
	} item_t;

	// Hand-over from the queue stage to the matrix stage.
	typedef struct packed {
		logic       valid;
		action_t    action;
		logic [7:0] read_select;
		logic [7:0] joystick_bits;
		logic       dequeue;
		kev_t       ev;
		logic       overflowed;
	} stage_t;

	function automatic logic [1:0] norm_force(input logic [1:0] f);
		logic [1:0] r;
		r = (f == FORCE_NEUTRAL || f == FORCE_DOWN || f == FORCE_UP) ? f : FORCE_NEUTRAL;
		return r;
	endfunction

endpackage

// ----- src/kmq_ram.sv -----
module kmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read returns the contents before a write at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/kmq_queue.sv -----
module kmq_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  kmq_pkg::item_t                   item,
	input  logic [kmq_pkg::THROTTLE_W-1:0]   throttle,
	output kmq_pkg::kev_t                    head_ev,
	output kmq_pkg::stage_t                  stage_s2
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int TW    = kmq_pkg::TIME_W;

	logic [PTR_W-1:0] head_q, tail_q, head_d;
	logic [CNT_W-1:0] count_q;
	logic [TW-1:0]    deadline_q;
	logic             overflow_q;
	logic             byp_q;
	kmq_pkg::kev_t    byp_ev_q;
	kmq_pkg::kev_t    ram_ev;
	logic             is_enq, is_read, is_clear, full, push, dequeue;
	logic [TW:0]      sum;
	logic [TW-1:0]    deadline_sat;
	kmq_pkg::stage_t  stage_d;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign is_enq   = item_valid && (item.action == kmq_pkg::ACT_ENQUEUE);
	assign is_read  = item_valid && (item.action == kmq_pkg::ACT_READ);
	assign is_clear = item_valid && (item.action == kmq_pkg::ACT_CLEAR);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push     = is_enq && !full;
	assign dequeue  = is_read && (item.cycle_time > deadline_q) && (count_q != '0);
	assign head_d   = dequeue ? ptr_inc(head_q) : head_q;

	assign sum          = {1'b0, item.cycle_time} + {{(TW + 1 - kmq_pkg::THROTTLE_W){1'b0}}, throttle};
	assign deadline_sat = sum[TW] ? '1 : sum[TW-1:0];

	kmq_ram #(
		.WIDTH(kmq_pkg::KEV_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo_ram (
		.clk  (clk),
		.we   (push),
		.waddr(tail_q),
		.wdata(item.ev),
		.raddr(head_d),
		.rdata(ram_ev)
	);

	// A write to the slot being read in the same cycle is forwarded.
	assign head_ev = byp_q ? byp_ev_q : ram_ev;

	always_ff @(posedge clk) begin
		byp_ev_q <= item.ev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			deadline_q <= '0;
			overflow_q <= 1'b0;
			byp_q      <= 1'b0;
		end else begin
			head_q <= head_d;
			byp_q  <= push && (tail_q == head_d);
			if (push) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_q + 1'b1;
			end else if (dequeue) begin
				count_q <= count_q - 1'b1;
			end
			if (is_enq && full) begin
				overflow_q <= 1'b1;
			end
			if (is_clear) begin
				deadline_q <= '0;
			end else if (dequeue) begin
				deadline_q <= deadline_sat;
			end
		end
	end

	always_comb begin
		stage_d.valid         = item_valid;
		stage_d.action        = item.action;
		stage_d.read_select   = item.read_select;
		stage_d.joystick_bits = item.joystick_bits;
		stage_d.dequeue       = dequeue;
		stage_d.ev            = head_ev;
		stage_d.overflowed    = overflow_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s2 <= '0;
		end else begin
			stage_s2 <= stage_d;
		end
	end

endmodule

// ----- src/kmq_matrix.sv -----
module kmq_matrix #(
	parameter int KEY_CODES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kmq_pkg::stage_t              stage_s2,
	input  logic [kmq_pkg::CODE_W-1:0]   lookup_code,
	input  logic [kmq_pkg::CODE_W-1:0]   left_code,
	input  logic [kmq_pkg::CODE_W-1:0]   right_code,
	output logic                         sweeping,
	output logic                         done,
	output logic [7:0]                   read_data,
	output logic                         queue_overflowed
);

	localparam int IDX_W  = $clog2(KEY_CODES);
	localparam int NCODES = 1 << kmq_pkg::CODE_W;

	logic [7:0]       matrix_q [8];
	logic [7:0]       matrix_d [8];
	logic [1:0]       fmode_q, fmode_d;
	logic             left_q, left_d, right_q, right_d;
	logic [7:0]       joy_q, joy_d;
	logic [IDX_W-1:0] idx_tab [NCODES];
	logic [IDX_W-1:0] cur_idx, look_idx, clr_cnt_q;
	logic             clearing_q;
	logic             sap_rdata, sap_old, shifted, use_alt;
	logic             sap_we, sap_wval;
	logic             ram_we, ram_wval;
	logic [IDX_W-1:0] ram_waddr;
	logic             lw_valid_q, lw_val_q;
	logic [IDX_W-1:0] lw_idx_q;
	logic [5:0]       pos;
	logic [7:0]       rd_d, k;
	kmq_pkg::kev_t    ev;

	// Key code to shift-record index, folded into the table size.
	for (genvar g = 0; g < NCODES; g++) begin : g_idx
		assign idx_tab[g] = IDX_W'(g % KEY_CODES);
	end

	assign ev       = stage_s2.ev;
	assign cur_idx  = idx_tab[ev.code];
	assign look_idx = idx_tab[lookup_code];

	assign ram_we    = clearing_q || sap_we;
	assign ram_waddr = clearing_q ? clr_cnt_q : cur_idx;
	assign ram_wval  = clearing_q ? 1'b0 : sap_wval;

	kmq_ram #(
		.WIDTH(1),
		.DEPTH(KEY_CODES)
	) u_sap_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wval),
		.raddr(look_idx),
		.rdata(sap_rdata)
	);

	// A record written at the edge that also loaded the read data is not yet in it.
	assign sap_old = (lw_valid_q && lw_idx_q == cur_idx) ? lw_val_q : sap_rdata;

	always_comb begin
		matrix_d = matrix_q;
		fmode_d  = fmode_q;
		left_d   = left_q;
		right_d  = right_q;
		joy_d    = joy_q;
		sap_we   = 1'b0;
		sap_wval = 1'b0;
		shifted  = 1'b0;
		use_alt  = 1'b0;
		pos      = ev.plain_pos;
		if (stage_s2.valid) begin
			case (stage_s2.action)
				kmq_pkg::ACT_CLEAR: begin
					for (int i = 0; i < 8; i++) begin
						matrix_d[i] = '0;
					end
					fmode_d = kmq_pkg::FORCE_NEUTRAL;
					left_d  = 1'b0;
					right_d = 1'b0;
				end
				kmq_pkg::ACT_JOYSTICK: begin
					joy_d = stage_s2.joystick_bits;
				end
				kmq_pkg::ACT_READ: begin
					if (stage_s2.dequeue) begin
						if (ev.code == left_code) begin
							left_d = ev.press;
						end
						if (ev.code == right_code) begin
							right_d = ev.press;
						end
						if (ev.press) begin
							shifted  = left_d || right_d;
							sap_we   = 1'b1;
							sap_wval = shifted;
						end else begin
							shifted = sap_old;
						end
						use_alt = shifted && (ev.smode == kmq_pkg::SMODE_MAPPED ||
							ev.smode == kmq_pkg::SMODE_IGNORE);
						if (!(use_alt && ev.smode == kmq_pkg::SMODE_IGNORE)) begin
							pos     = use_alt ? ev.shifted_pos : ev.plain_pos;
							fmode_d = kmq_pkg::norm_force(use_alt ? ev.shifted_fc : ev.plain_fc);
							matrix_d[pos[5:3]][pos[2:0]] = ev.press;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rd_d = '0;
		for (int i = 0; i < 8; i++) begin
			k = matrix_d[i];
			if (i == kmq_pkg::JOYSTICK_BYTE) begin
				k = k | joy_d;
			end
			if (i == kmq_pkg::SHIFT_BYTE) begin
				if (fmode_d == kmq_pkg::FORCE_UP) begin
					k = k & ~kmq_pkg::FORCE_UP_MASK;
				end else if (fmode_d == kmq_pkg::FORCE_DOWN) begin
					k = k | kmq_pkg::FORCE_DOWN_SET;
				end
			end
			if (stage_s2.read_select[i]) begin
				rd_d = rd_d | k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				matrix_q[i] <= '0;
			end
			fmode_q    <= kmq_pkg::FORCE_NEUTRAL;
			left_q     <= 1'b0;
			right_q    <= 1'b0;
			joy_q      <= '0;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			lw_valid_q <= 1'b0;
			done       <= 1'b0;
		end else begin
			matrix_q   <= matrix_d;
			fmode_q    <= fmode_d;
			left_q     <= left_d;
			right_q    <= right_d;
			joy_q      <= joy_d;
			lw_valid_q <= sap_we;
			done       <= stage_s2.valid && (stage_s2.action == kmq_pkg::ACT_READ);
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == IDX_W'(KEY_CODES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		lw_idx_q         <= cur_idx;
		lw_val_q         <= sap_wval;
		read_data        <= rd_d;
		queue_overflowed <= stage_s2.overflowed;
	end

	assign sweeping = clearing_q;

endmodule

// ----- src/keyboard_matrix_with_event_queue.sv -----
// Emulated keyboard matrix of eight bytes, fed by a queue of key events.
//
// Commands enter on start while busy is low; every field of the command is
// taken at that edge. Enqueue stores a key event (or drops it and sets the
// sticky overflow flag when the queue is full), clear empties the matrix and
// the shift state, set joystick loads the joystick byte, and a keyboard read
// may take one event from the queue before it forms its answer.
// Only a keyboard read produces a result. The result transfer is marked by
// done for one cycle, once the command has passed the input register and
// the queue-stage register into the result register; the receiver cannot
// hold it off, so the pipeline never stalls. The design is a short pipeline
// of an input register, a queue stage and a matrix stage followed by the
// result register, so after the reset sweep a command can be taken on every
// clock; throughput is one command per cycle. After reset the per-key shift
// record is swept to zero, one entry a cycle, which keeps busy high until
// the sweep ends. Configuration writes are taken at any time, on each edge
// at which cfg_we is high; an index beyond the last register is ignored.
module keyboard_matrix_with_event_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int KEY_CODES   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [39:0] cycle_time,
	input  logic [7:0]  read_select,
	input  logic [7:0]  joystick_bits,
	input  logic [7:0]  key_code,
	input  logic        is_press,
	input  logic [5:0]  plain_position,
	input  logic [1:0]  plain_force,
	input  logic [1:0]  shifted_mode,
	input  logic [5:0]  shifted_position,
	input  logic [1:0]  shifted_force,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        queue_overflowed
);

	logic [kmq_pkg::THROTTLE_W-1:0] throttle_q;
	logic [kmq_pkg::CODE_W-1:0]     left_code_q, right_code_q;
	logic                           valid_s1;
	kmq_pkg::item_t                 item_s1, item_d;
	kmq_pkg::kev_t                  head_ev;
	kmq_pkg::stage_t                stage_s2;
	logic                           sweeping;
	logic                           accept;

	// Configuration registers: plain writes, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q   <= kmq_pkg::THROTTLE_RESET;
			left_code_q  <= kmq_pkg::LEFT_SHIFT_RESET;
			right_code_q <= kmq_pkg::RIGHT_SHIFT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kmq_pkg::CFG_THROTTLE:    throttle_q   <= cfg_data;
				kmq_pkg::CFG_LEFT_SHIFT:  left_code_q  <= cfg_data[7:0];
				kmq_pkg::CFG_RIGHT_SHIFT: right_code_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// A command is taken whenever the sweep after reset has finished.
	assign busy   = sweeping;
	assign accept = start && !busy;

	always_comb begin
		item_d.action           = kmq_pkg::action_t'(action);
		item_d.cycle_time       = cycle_time;
		item_d.read_select      = read_select;
		item_d.joystick_bits    = joystick_bits;
		item_d.ev.code          = key_code;
		item_d.ev.press         = is_press;
		item_d.ev.plain_pos     = plain_position;
		item_d.ev.plain_fc      = plain_force;
		item_d.ev.smode         = shifted_mode;
		item_d.ev.shifted_pos   = shifted_position;
		item_d.ev.shifted_fc    = shifted_force;
	end

	// Input register: the first pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_d;
	end

	// Queue stage: enqueue, overflow flag, throttle deadline and the
	// decision whether a read takes the event at the head of the queue.
	kmq_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(valid_s1),
		.item      (item_s1),
		.throttle  (throttle_q),
		.head_ev   (head_ev),
		.stage_s2  (stage_s2)
	);

	// Matrix stage: shift tracking, the per-key shift record, the matrix
	// update and the read answer, registered onto the result ports.
	kmq_matrix #(
		.KEY_CODES(KEY_CODES)
	) u_matrix (
		.clk             (clk),
		.arst_n          (arst_n),
		.stage_s2        (stage_s2),
		.lookup_code     (head_ev.code),
		.left_code       (left_code_q),
		.right_code      (right_code_q),
		.sweeping        (sweeping),
		.done            (done),
		.read_data       (read_data),
		.queue_overflowed(queue_overflowed)
	);

endmodule

// ----- sim/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kmq_pkg::*;

	// The queue depth and key-code count match the defaults of the block.
	localparam int QUEUE_DEPTH   = 16;
	localparam int KEY_CODES     = 256;
	// The settling wait is well longer than the pipeline; this gives a comfortable margin.
	localparam int SETTLE_CYCLES = 8;
	// Longest stretch without any transfer; the reset sweep is the worst honest case.
	localparam int STALL_LIMIT   = 2000;
	localparam int REPORT_LIMIT  = 100;

	// The one register index that the block has no register behind.
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [TIME_W-1:0] TIME_TOP = '1;
	localparam logic [THROTTLE_W-1:0] THROTTLE_MAX = '1;

	typedef struct packed {
		logic [7:0] data;
		logic       overflowed;
	} read_answer_t;

	// Every input of the block starts at a known value.
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [1:0]             action = ACT_ENQUEUE;
	logic [TIME_W-1:0]      cycle_time = '0;
	logic [7:0]             read_select = '0;
	logic [7:0]             joystick_bits = '0;
	logic [CODE_W-1:0]      key_code = '0;
	logic                   is_press = 1'b0;
	logic [POS_W-1:0]       plain_position = '0;
	logic [1:0]             plain_force = FORCE_NEUTRAL;
	logic [1:0]             shifted_mode = SMODE_PLAIN;
	logic [POS_W-1:0]       shifted_position = '0;
	logic [1:0]             shifted_force = FORCE_NEUTRAL;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_THROTTLE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   done;
	logic [7:0]             read_data;
	logic                   queue_overflowed;

	// Our own copy of the keyboard state, advanced at each accepted command.
	logic [7:0]            matrix_model [8];
	logic [1:0]            force_model;
	logic                  lshift_model;
	logic                  rshift_model;
	logic [TIME_W-1:0]     deadline_model;
	kev_t                  key_queue [$];
	logic                  shift_held_model [KEY_CODES];
	logic [7:0]            joy_model;
	logic                  overflow_model;
	logic [THROTTLE_W-1:0] throttle_model;
	logic [CODE_W-1:0]     lcode_model;
	logic [CODE_W-1:0]     rcode_model;

	// Answers still owed by the block, oldest first.
	read_answer_t reads_due [$];

	int          mismatches = 0;
	int          stall_cycles = 0;
	bit          idle_enabled = 1'b1;
	logic [39:0] machine_time = 40'd1 << 24;
	logic [7:0]  key_pool [6];

	keyboard_matrix_with_event_queue i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.cycle_time       (cycle_time),
		.read_select      (read_select),
		.joystick_bits    (joystick_bits),
		.key_code         (key_code),
		.is_press         (is_press),
		.plain_position   (plain_position),
		.plain_force      (plain_force),
		.shifted_mode     (shifted_mode),
		.shifted_position (shifted_position),
		.shifted_force    (shifted_force),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.read_data        (read_data),
		.queue_overflowed (queue_overflowed)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A mismatch prints one line while the count is modest, so a badly broken
	// block cannot flood the log, but every mismatch is counted.
	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("MISMATCH at %0t ns: %s got %02h expected %02h", $time, what, got, want);
		end
	endtask

	// Clear keyboard touches the matrix, the force mode, both shift flags and the
	// deadline only; reset does the same and then some.
	task automatic clear_matrix_model();
		for (int i = 0; i < 8; i++) begin
			matrix_model[i] = '0;
		end
		force_model = FORCE_NEUTRAL;
		lshift_model = 1'b0;
		rshift_model = 1'b0;
		deadline_model = '0;
	endtask

	// Works out what one accepted command does to the keyboard state and, for a
	// keyboard read, which answer the block owes.
	task automatic predict_command(input item_t it);
		logic [TIME_W:0]  sum;
		logic [7:0]       k;
		logic [7:0]       answer;
		kev_t             ev;
		logic             shifted;
		logic             use_alt;
		logic [POS_W-1:0] pos;
		logic [1:0]       fc;
		read_answer_t     due;
		case (it.action)
			ACT_ENQUEUE: begin
				// A full queue drops the event and the flag sticks until reset.
				if (key_queue.size() >= QUEUE_DEPTH) begin
					overflow_model = 1'b1;
				end else begin
					key_queue.push_back(it.ev);
				end
			end
			ACT_CLEAR: begin
				clear_matrix_model();
			end
			ACT_JOYSTICK: begin
				joy_model = it.joystick_bits;
			end
			default: begin
				// Only a read strictly past the deadline takes an event off the queue.
				if (it.cycle_time > deadline_model && key_queue.size() > 0) begin
					ev = key_queue[0];
					key_queue.delete(0);
					if (ev.code == lcode_model) begin
						lshift_model = ev.press;
					end
					if (ev.code == rcode_model) begin
						rshift_model = ev.press;
					end
					// A press records the shift state for its key; the release
					// of that key replays the recorded state.
					if (ev.press) begin
						shifted = lshift_model | rshift_model;
						shift_held_model[ev.code] = shifted;
					end else begin
						shifted = shift_held_model[ev.code];
					end
					use_alt = shifted && (ev.smode == SMODE_MAPPED || ev.smode == SMODE_IGNORE);
					// With shift in effect an ignore-mode key leaves the matrix alone.
					if (!(use_alt && ev.smode == SMODE_IGNORE)) begin
						pos = use_alt ? ev.shifted_pos : ev.plain_pos;
						fc = use_alt ? ev.shifted_fc : ev.plain_fc;
						force_model = (fc == FORCE_DOWN || fc == FORCE_UP) ? fc : FORCE_NEUTRAL;
						matrix_model[pos[5:3]][pos[2:0]] = ev.press;
					end
					// The new deadline saturates at the top of the time range.
					sum = {1'b0, it.cycle_time} + {21'd0, throttle_model};
					deadline_model = sum[TIME_W] ? TIME_TOP : sum[TIME_W-1:0];
				end
				answer = '0;
				for (int i = 0; i < 8; i++) begin
					if (it.read_select[i]) begin
						k = matrix_model[i];
						if (i == JOYSTICK_BYTE) begin
							k = k | joy_model;
						end
						if (i == SHIFT_BYTE) begin
							if (force_model == FORCE_UP) begin
								k = k & ~FORCE_UP_MASK;
							end else if (force_model == FORCE_DOWN) begin
								k = k | FORCE_DOWN_SET;
							end
						end
						answer = answer | k;
					end
				end
				due.data = answer;
				due.overflowed = overflow_model;
				reads_due.push_back(due);
			end
		endcase
	endtask

	// Drives one command and holds it until the block takes it. Start is left
	// high afterwards, so back-to-back commands need no second assignment to it
	// in the same step; an idle burst lowers it instead.
	task automatic send_command(input item_t it);
		action <= it.action;
		cycle_time <= it.cycle_time;
		read_select <= it.read_select;
		joystick_bits <= it.joystick_bits;
		key_code <= it.ev.code;
		is_press <= it.ev.press;
		plain_position <= it.ev.plain_pos;
		plain_force <= it.ev.plain_fc;
		shifted_mode <= it.ev.smode;
		shifted_position <= it.ev.shifted_pos;
		shifted_force <= it.ev.shifted_fc;
		start <= 1'b1;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		predict_command(it);
		if (idle_enabled && $urandom_range(0, 7) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every owed answer has come, then lets the
	// pipeline empty itself of commands that owe no answer.
	task automatic wait_for_idle();
		start <= 1'b0;
		while (reads_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A register write is taken at the edge where the enable is high, and the enable is then lowered.
	task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (index)
			CFG_THROTTLE: begin
				throttle_model = value;
			end
			CFG_LEFT_SHIFT: begin
				lcode_model = value[CODE_W-1:0];
			end
			CFG_RIGHT_SHIFT: begin
				rcode_model = value[CODE_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	function automatic item_t key_event(input logic [7:0] code, input logic press,
			input logic [5:0] ppos, input logic [1:0] pfc, input logic [1:0] smode,
			input logic [5:0] spos, input logic [1:0] sfc);
		item_t it;
		it = '0;
		it.action = ACT_ENQUEUE;
		it.ev.code = code;
		it.ev.press = press;
		it.ev.plain_pos = ppos;
		it.ev.plain_fc = pfc;
		it.ev.smode = smode;
		it.ev.shifted_pos = spos;
		it.ev.shifted_fc = sfc;
		return it;
	endfunction

	function automatic item_t keyboard_read(input logic [TIME_W-1:0] now,
			input logic [7:0] sel);
		item_t it;
		it = '0;
		it.action = ACT_READ;
		it.cycle_time = now;
		it.read_select = sel;
		return it;
	endfunction

	function automatic item_t plain_command(input action_t act, input logic [7:0] joy);
		item_t it;
		it = '0;
		it.action = act;
		it.joystick_bits = joy;
		return it;
	endfunction

	// A small set of keys is pressed and released over and over, so that most
	// releases find a recorded press; the shift keys are drawn besides them.
	task automatic refresh_key_pool();
		for (int i = 0; i < 6; i++) begin
			key_pool[i] = 8'($urandom);
		end
	endtask

	// Random command, with every field filled whether it is used or not. Reads
	// mostly follow a rising machine clock so that the throttle sometimes holds
	// the queue back and sometimes lets an event through.
	function automatic item_t random_command();
		item_t       it;
		logic [31:0] r1;
		logic [31:0] r2;
		logic [31:0] r3;
		int unsigned pick;
		r1 = $urandom;
		r2 = $urandom;
		r3 = $urandom;
		it.read_select = r1[7:0];
		it.joystick_bits = r1[15:8];
		it.ev.press = r1[16];
		it.ev.plain_pos = r1[22:17];
		it.ev.plain_fc = r1[24:23];
		it.ev.smode = r1[26:25];
		it.ev.shifted_pos = r2[5:0];
		it.ev.shifted_fc = r2[7:6];
		it.ev.code = r2[15:8];
		it.cycle_time = {r2[23:16], r3};
		case ($urandom_range(0, 9))
			0: it.ev.code = lcode_model;
			1: it.ev.code = rcode_model;
			2: begin
			end
			default: it.ev.code = key_pool[$urandom_range(0, 5)];
		endcase
		pick = $urandom_range(0, 99);
		// The queue is kept from filling here; overflow has a test of its own.
		if (pick < 42 && key_queue.size() < QUEUE_DEPTH) begin
			it.action = ACT_ENQUEUE;
		end else if (pick < 88) begin
			it.action = ACT_READ;
			if ($urandom_range(0, 3) == 0) begin
				it.read_select = 8'hFF;
			end
			if ($urandom_range(0, 49) != 0) begin
				machine_time = machine_time
					+ TIME_W'($urandom_range(0, 2 * int'(throttle_model) + 2));
				it.cycle_time = machine_time;
			end
		end else if (pick < 93) begin
			it.action = ACT_CLEAR;
		end else begin
			it.action = ACT_JOYSTICK;
		end
		return it;
	endfunction

	task automatic run_random_commands(input int count);
		repeat (count) begin
			send_command(random_command());
			if (idle_enabled && $urandom_range(0, 79) == 0) begin
				wait_for_idle();
			end
		end
	endtask

	// Unshifted keys at both ends of the matrix, down, up and unused force codes,
	// joystick merge into byte 6, and reads with no byte and every byte selected.
	task automatic test_plain_keys();
		write_register(CFG_THROTTLE, 20'd0);
		send_command(keyboard_read(40'd1, 8'hFF));
		send_command(key_event(8'h10, 1'b1, 6'd0, FORCE_DOWN, SMODE_PLAIN, 6'd0, FORCE_NEUTRAL));
		send_command(key_event(8'h20, 1'b1, 6'd63, 2'd3, 2'd3, 6'd5, FORCE_UP));
		send_command(keyboard_read(40'd2, 8'h01));
		send_command(keyboard_read(40'd3, 8'h80));
		send_command(key_event(8'h10, 1'b0, 6'd0, FORCE_UP, SMODE_PLAIN, 6'd0, FORCE_NEUTRAL));
		send_command(keyboard_read(40'd4, 8'hFF));
		send_command(plain_command(ACT_JOYSTICK, 8'hA5));
		send_command(keyboard_read(40'd5, 8'h40));
		send_command(keyboard_read(40'd6, 8'h00));
	endtask

	// Shifted mapping, ignore when shifted, a release that replays the shift
	// state recorded at its press, and a mapped key with no shift held.
	task automatic test_shift_mapping();
		wait_for_idle();
		write_register(CFG_LEFT_SHIFT, 20'h00000);
		write_register(CFG_RIGHT_SHIFT, 20'hFFF80);
		send_command(key_event(8'h00, 1'b1, 6'd56, FORCE_NEUTRAL, SMODE_PLAIN, 6'd0, FORCE_NEUTRAL));
		send_command(key_event(8'h41, 1'b1, 6'd3, FORCE_NEUTRAL, SMODE_MAPPED, 6'd12, FORCE_DOWN));
		send_command(key_event(8'h42, 1'b1, 6'd9, FORCE_DOWN, SMODE_IGNORE, 6'd10, FORCE_UP));
		send_command(key_event(8'h00, 1'b0, 6'd56, FORCE_NEUTRAL, SMODE_PLAIN, 6'd0, FORCE_NEUTRAL));
		send_command(key_event(8'h41, 1'b0, 6'd3, FORCE_NEUTRAL, SMODE_MAPPED, 6'd12, FORCE_UP));
		send_command(key_event(8'h43, 1'b1, 6'd20, FORCE_DOWN, SMODE_MAPPED, 6'd30, FORCE_UP));
		for (int i = 0; i < 6; i++) begin
			send_command(keyboard_read(40'd11 + 40'(i), 8'hFF));
		end
	endtask

	// Largest throttle, a read exactly on the deadline, a saturated deadline,
	// equal shift codes, a write to the spare index, and clear keyboard with
	// an event still waiting in the queue.
	task automatic test_throttle_and_clear();
		wait_for_idle();
		write_register(CFG_THROTTLE, THROTTLE_MAX);
		write_register(CFG_LEFT_SHIFT, 20'h0005A);
		write_register(CFG_RIGHT_SHIFT, 20'h0005A);
		write_register(CFG_SPARE, 20'd0);
		send_command(key_event(8'h5A, 1'b1, 6'd2, FORCE_DOWN, SMODE_PLAIN, 6'd0, FORCE_NEUTRAL));
		send_command(keyboard_read(40'd100, 8'hFF));
		send_command(key_event(8'h5A, 1'b0, 6'd2, FORCE_NEUTRAL, SMODE_PLAIN, 6'd0, FORCE_NEUTRAL));
		send_command(keyboard_read(40'd100 + TIME_W'(THROTTLE_MAX), 8'hFF));
		send_command(keyboard_read(40'd101 + TIME_W'(THROTTLE_MAX), 8'hFF));
		send_command(key_event(8'h62, 1'b1, 6'd1, FORCE_UP, SMODE_PLAIN, 6'd0, FORCE_NEUTRAL));
		send_command(keyboard_read(TIME_TOP - 40'd1, 8'hFF));
		send_command(key_event(8'h63, 1'b1, 6'd1, FORCE_NEUTRAL, SMODE_PLAIN, 6'd0, FORCE_NEUTRAL));
		send_command(keyboard_read(TIME_TOP, 8'hFF));
		send_command(plain_command(ACT_CLEAR, 8'h00));
		send_command(keyboard_read(40'd0, 8'hFF));
		send_command(keyboard_read(40'd1, 8'hFF));
	endtask

	// Random traffic under three settings: a short throttle with random shift
	// codes, no throttle with both shift codes equal, and a throttle of any size.
	task automatic test_random_traffic();
		logic [7:0] code;
		wait_for_idle();
		write_register(CFG_THROTTLE, 20'($urandom_range(0, 40)));
		write_register(CFG_LEFT_SHIFT, 20'($urandom));
		write_register(CFG_RIGHT_SHIFT, 20'($urandom));
		refresh_key_pool();
		run_random_commands(200);
		wait_for_idle();
		code = 8'($urandom);
		write_register(CFG_THROTTLE, 20'd0);
		write_register(CFG_LEFT_SHIFT, {12'($urandom), code});
		write_register(CFG_RIGHT_SHIFT, {12'($urandom), code});
		refresh_key_pool();
		run_random_commands(150);
		wait_for_idle();
		write_register(CFG_THROTTLE, 20'($urandom));
		write_register(CFG_LEFT_SHIFT, 20'($urandom));
		write_register(CFG_RIGHT_SHIFT, 20'($urandom));
		refresh_key_pool();
		run_random_commands(100);
	endtask

	// Enough events to overrun the queue, then reads until it has drained; from
	// here on the sticky flag must read as set.
	task automatic test_queue_overflow();
		item_t it;
		wait_for_idle();
		write_register(CFG_THROTTLE, 20'd0);
		repeat (QUEUE_DEPTH + 4) begin
			it = random_command();
			it.action = ACT_ENQUEUE;
			send_command(it);
		end
		repeat (QUEUE_DEPTH + 8) begin
			it = random_command();
			machine_time = machine_time + 40'd1;
			it.action = ACT_READ;
			it.cycle_time = machine_time;
			send_command(it);
		end
	endtask

	// The closing stretch runs with no idling at all and the extreme shift codes.
	task automatic test_quiet_tail();
		wait_for_idle();
		idle_enabled = 1'b0;
		write_register(CFG_THROTTLE, 20'd1);
		write_register(CFG_LEFT_SHIFT, 20'h00000);
		write_register(CFG_RIGHT_SHIFT, 20'h000FF);
		refresh_key_pool();
		run_random_commands(100);
	endtask

	// Each result is taken at the edge that ends its strobe cycle and compared
	// with the oldest answer owed.
	always @(posedge clk) begin : check_results
		read_answer_t want;
		if (done === 1'b1) begin
			if (reads_due.size() == 0) begin
				report_mismatch("result with nothing owed, read_data", read_data, 8'h00);
			end else begin
				want = reads_due[0];
				reads_due.delete(0);
				if (read_data !== want.data) begin
					report_mismatch("read_data", read_data, want.data);
				end
				if (queue_overflowed !== want.overflowed) begin
					report_mismatch("queue_overflowed", {7'd0, queue_overflowed},
						{7'd0, want.overflowed});
				end
			end
		end
	end

	// Any command transfer or result transfer counts as progress; a block that
	// stops making progress ends the run.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		// The model starts from the reset state of the block.
		clear_matrix_model();
		for (int i = 0; i < KEY_CODES; i++) begin
			shift_held_model[i] = 1'b0;
		end
		joy_model = '0;
		overflow_model = 1'b0;
		throttle_model = THROTTLE_RESET;
		lcode_model = LEFT_SHIFT_RESET;
		rcode_model = RIGHT_SHIFT_RESET;
		refresh_key_pool();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The block sweeps its key record after reset; the first transfer simply
		// waits for busy to fall.
		test_plain_keys();
		test_shift_mapping();
		test_throttle_and_clear();
		test_random_traffic();
		test_queue_overflow();
		test_quiet_tail();
		wait_for_idle();

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
